/* hw/rtl/ostt_pkg.sv */
// Shared types and codes for the one-shot timer table.
package ostt_pkg;

	localparam int CMD_W = 2;
	localparam int KIND_W = 3;
	localparam int ID_W = 16;
	localparam int TIME_W = 32;
	localparam int SLOT_W = 3;
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 24;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNSET = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	localparam logic [KIND_W-1:0] KIND_SET_OK = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FULL = 3'd1;
	localparam logic [KIND_W-1:0] KIND_UNSET_OK = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FIRED = 3'd4;
	localparam logic [KIND_W-1:0] KIND_IDLE = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic step;
		logic take;
		logic fin;
	} ctrl_t;

	typedef struct packed {
		logic in_ok;
		logic hit;
		logic last_slot;
		logic is_tick;
		logic need_push;
		logic out_free;
	} stat_t;

endpackage

/* hw/rtl/ostt_ctrl.sv */
// Controller state machine for the timer table slot scan.
module ostt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  ostt_pkg::stat_t st,
	output ostt_pkg::ctrl_t ctl
);
	import ostt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   can_take;

	assign can_take = !st.need_push || st.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && st.in_ok) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (st.hit) begin
					if (can_take) begin
						if (!st.is_tick) state_d = ST_IDLE;
						else if (st.last_slot) state_d = ST_FINISH;
						else state_d = ST_READ;
					end
				end else begin
					if (!st.last_slot) state_d = ST_READ;
					else if (st.is_tick) state_d = ST_FINISH;
					else if (st.out_free) state_d = ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ctl.load = s_tvalid;
			end
			ST_READ: begin
				ctl.rd = 1'b1;
			end
			ST_EVAL: begin
				if (st.hit) begin
					if (can_take) begin
						ctl.take = 1'b1;
						ctl.step = st.is_tick && !st.last_slot;
					end
				end else begin
					if (!st.last_slot) ctl.step = 1'b1;
					else if (!st.is_tick) ctl.fin = st.out_free;
				end
			end
			ST_FINISH: begin
				ctl.fin = st.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/ostt_dp.sv */
// Datapath of the timer table: slot memories, counter, scan index and result register.
module ostt_dp #(
	parameter int SLOT_COUNT = 8,
	parameter int IDX_W = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ostt_pkg::ctrl_t                      ctl,
	output ostt_pkg::stat_t                      st,
	input  logic [ostt_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [ostt_pkg::CMD_W-1:0]           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ostt_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [ostt_pkg::KIND_W-1:0]          m_tuser,
	output logic                                 m_tlast
);
	import ostt_pkg::*;

	logic [ID_W-1:0]   owner_mem [SLOT_COUNT];
	logic [TIME_W-1:0] dl_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;

	logic [TIME_W-1:0] time_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] dly_q;
	logic [IDX_W-1:0]  idx_q;

	logic              rd_valid_q;
	logic [ID_W-1:0]   rd_owner_q;
	logic [TIME_W-1:0] rd_dl_q;

	logic              pend_q;
	logic [ID_W-1:0]   pend_owner_q;
	logic [SLOT_W-1:0] pend_slot_q;

	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [ID_W-1:0]   out_handler_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_last_q;

	logic [ID_W-1:0]   eff_owner;
	logic [SLOT_W-1:0] cur_slot;
	logic              push;
	logic [KIND_W-1:0] res_kind;
	logic [ID_W-1:0]   res_handler;
	logic [SLOT_W-1:0] res_slot;
	logic              res_last;

	assign eff_owner = rd_valid_q ? rd_owner_q : '0;
	assign cur_slot = SLOT_W'(idx_q);

	always_comb begin
		st.in_ok = (s_tuser != CMD_NONE);
		st.is_tick = (cmd_q == CMD_TICK);
		st.last_slot = (idx_q == IDX_W'(SLOT_COUNT - 1));
		st.need_push = (cmd_q != CMD_TICK) || pend_q;
		st.out_free = !out_valid_q || m_tready;
		case (cmd_q)
			CMD_TICK: st.hit = rd_valid_q && (rd_dl_q <= time_q);
			CMD_SET: st.hit = !rd_valid_q;
			CMD_UNSET: st.hit = (eff_owner == id_q);
			default: st.hit = 1'b0;
		endcase
	end

	assign push = (ctl.take && ((cmd_q != CMD_TICK) || pend_q)) || ctl.fin;

	always_comb begin
		res_kind = KIND_IDLE;
		res_handler = '0;
		res_slot = '0;
		res_last = 1'b1;
		if (ctl.take) begin
			case (cmd_q)
				CMD_SET: begin
					res_kind = KIND_SET_OK;
					res_slot = cur_slot;
				end
				CMD_UNSET: begin
					res_kind = KIND_UNSET_OK;
					res_slot = cur_slot;
				end
				default: begin
					res_kind = KIND_FIRED;
					res_handler = pend_owner_q;
					res_slot = pend_slot_q;
					res_last = 1'b0;
				end
			endcase
		end else begin
			case (cmd_q)
				CMD_SET: res_kind = KIND_FULL;
				CMD_UNSET: res_kind = KIND_NOT_FOUND;
				default: begin
					if (pend_q) begin
						res_kind = KIND_FIRED;
						res_handler = pend_owner_q;
						res_slot = pend_slot_q;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			cmd_q <= CMD_NONE;
			idx_q <= '0;
			valid_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				cmd_q <= s_tuser;
				idx_q <= '0;
				pend_q <= 1'b0;
				if (s_tuser == CMD_TICK) time_q <= time_q + TIME_W'(1);
			end
			if (ctl.step) idx_q <= idx_q + IDX_W'(1);
			if (ctl.take) begin
				if (cmd_q == CMD_SET) valid_q[idx_q] <= (id_q != '0);
				else valid_q[idx_q] <= 1'b0;
				if (cmd_q == CMD_TICK) pend_q <= 1'b1;
			end
			if (push) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q <= s_tdata[15:0];
			dly_q <= (s_tdata[47:16] == '0) ? TIME_W'(1) : s_tdata[47:16];
		end
		if (ctl.rd) begin
			rd_valid_q <= valid_q[idx_q];
			rd_owner_q <= owner_mem[idx_q];
			rd_dl_q <= dl_mem[idx_q];
		end
		if (ctl.take && (cmd_q == CMD_SET)) begin
			owner_mem[idx_q] <= id_q;
			dl_mem[idx_q] <= time_q + dly_q;
		end
		if (ctl.take && (cmd_q == CMD_TICK)) begin
			pend_owner_q <= rd_owner_q;
			pend_slot_q <= cur_slot;
		end
		if (push) begin
			out_kind_q <= res_kind;
			out_handler_q <= res_handler;
			out_slot_q <= res_slot;
			out_last_q <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {5'd0, out_slot_q, out_handler_q};

endmodule

/* hw/rtl/one_shot_timer_table_top.sv */
// Flow: a set or unset scans the slots from slot 0 until it stops at slot k or misses all of
// them; a tick scans every slot, then finishes once the output register is free.
// Throughput: one transaction at a time; each slot passes through a memory read state and an
// evaluate state, so the slot scan sets the rate. Results leave through one output register.
// Reset: asynchronous, active low; clears the counter and every slot's armed bit at once.
module one_shot_timer_table_top #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ostt_pkg::IN_DATA_W-1:0]     s_tdata,  // handler_id[15:0], delay[47:16]
	input  logic [ostt_pkg::CMD_W-1:0]         s_tuser,  // cmd[1:0]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ostt_pkg::OUT_DATA_W-1:0]    m_tdata,  // fired_handler[15:0], slot_index[18:16]
	output logic [ostt_pkg::KIND_W-1:0]        m_tuser,  // kind[2:0]
	output logic                               m_tlast
);
	import ostt_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	ctrl_t ctl;
	stat_t st;

	ostt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.ctl      (ctl)
	);

	ostt_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.st       (st),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
